### sv/ellipse_midpoint_rasterizer_defines.svh
// assertion macros shared by the rasterizer modules
`ifndef ELLIPSE_MIDPOINT_RASTERIZER_DEFINES_SVH
`define ELLIPSE_MIDPOINT_RASTERIZER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication under synchronous active-low reset
`define EMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rasterizer check failed");

// next-cycle implication under synchronous active-low reset
`define EMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rasterizer check failed");

`else

`define EMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define EMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/emr_pkg.sv
`default_nettype none

package emr_pkg;

    localparam int RAD_W   = 10;           // config register width
    localparam int SQ_W    = 2 * RAD_W;    // squared radius
    localparam int OX_W    = 12;           // horizontal offset
    localparam int OY_W    = 11;           // vertical offset
    localparam int MB_W    = OX_W;         // narrow multiplier operand
    localparam int PROD_W  = SQ_W + MB_W;  // product width
    localparam int DEC_W   = 48;           // decision value
    localparam int XO_W    = 13;           // x output coordinate
    localparam int YO_W    = 12;           // y output coordinate
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

    // multiplier operation select
    localparam int MUL_SEL_W = 3;
    localparam logic [MUL_SEL_W-1:0] MUL_RX2  = 3'd0;  // rx * rx
    localparam logic [MUL_SEL_W-1:0] MUL_RY2  = 3'd1;  // ry * ry
    localparam logic [MUL_SEL_W-1:0] MUL_INIT = 3'd2;  // rx2 * ry, loads start values
    localparam logic [MUL_SEL_W-1:0] MUL_A    = 3'd3;  // ry2 * x
    localparam logic [MUL_SEL_W-1:0] MUL_B    = 3'd4;  // rx2 * y

    typedef struct packed {
        logic                 mul_en;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 upd;
    } t_dp_cmd;

endpackage

`default_nettype wire

### sv/ellipse_midpoint_rasterizer.sv
// channel   | dir | beat signals                       | payload
// ----------+-----+------------------------------------+---------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready      | tdata[0] restart
// m_axis    | out | m_axis_tvalid / m_axis_tready      | tdata x_right,x_left,y_high,y_low;
//           |     |                                    | tuser point_valid; tlast last_point
// cfg       | in  | i_cfg_we (no wait, no read-back)   | i_cfg_idx, i_cfg_data
//
// an item goes from accept to result through states SQX, SQY, (INIT on restart), PA, PB, UPD;
// the one shared 20x12 multiplier forms rx^2, ry^2, (rx^2*ry on restart), ry^2*x, rx^2*y in turn
// before the decision update; the next item can be taken in the cycle after the result is loaded
// synchronous active-low reset clears config, offsets, decision and the fsm
// a result waits in the output register while the next item is accepted and worked on;
// only the update step stalls when that register is still full
`default_nettype none

module ellipse_midpoint_rasterizer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [9:0]  i_cfg_data,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [12:0] x_right, [25:13] x_left,
                                        // [37:26] y_high, [49:38] y_low, [55:50] zero
    output logic        m_axis_tuser,   // [0] point_valid
    output logic        m_axis_tlast    // last point set of the ellipse
);

    emr_pkg::t_dp_cmd                     w_cmd;
    logic                                 w_y_zero;
    logic signed [emr_pkg::XO_W-1:0]      w_x_right, w_x_left;
    logic signed [emr_pkg::YO_W-1:0]      w_y_high, w_y_low;
    logic                                 w_point_valid, w_last_point;

    // sequencer: handshakes and multiplier schedule
    emr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_restart   (s_axis_tdata[0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    // config registers, walk state, multiplier and result register
    emr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_y_zero      (w_y_zero),
        .o_x_right     (w_x_right),
        .o_x_left      (w_x_left),
        .o_y_high      (w_y_high),
        .o_y_low       (w_y_low),
        .o_point_valid (w_point_valid),
        .o_last_point  (w_last_point)
    );

    // pack result fields, lowest field first
    assign m_axis_tdata = {6'b0, w_y_low, w_y_high, w_x_left, w_x_right};
    assign m_axis_tuser = w_point_valid;
    // y_zero does not reach the sequencer; it is folded into tlast gating only
    assign m_axis_tlast = w_last_point & ~(w_y_zero & ~w_point_valid);

endmodule

`default_nettype wire

### sv/emr_datapath.sv
`default_nettype none
`include "ellipse_midpoint_rasterizer_defines.svh"

module emr_datapath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [emr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [emr_pkg::RAD_W-1:0]          i_cfg_data,
    input  emr_pkg::t_dp_cmd                   i_cmd,
    output logic                               o_y_zero,
    output logic signed [emr_pkg::XO_W-1:0]    o_x_right,
    output logic signed [emr_pkg::XO_W-1:0]    o_x_left,
    output logic signed [emr_pkg::YO_W-1:0]    o_y_high,
    output logic signed [emr_pkg::YO_W-1:0]    o_y_low,
    output logic                               o_point_valid,
    output logic                               o_last_point
);

    logic [emr_pkg::RAD_W-1:0]  r_center_x, r_center_y, r_rad_x, r_rad_y;
    logic [emr_pkg::SQ_W-1:0]   r_rx2, r_ry2;
    logic [emr_pkg::PROD_W-1:0] r_a, r_b;
    logic [emr_pkg::OX_W-1:0]   r_x, n_x;
    logic [emr_pkg::OY_W-1:0]   r_y, n_y;
    logic [emr_pkg::DEC_W-1:0]  r_d, n_d, w_inc, w_d_init;
    logic [emr_pkg::DEC_W-1:0]  w_two_a, w_two_b, w_rx2e, w_ry2e;
    logic [emr_pkg::SQ_W-1:0]   w_op_a;
    logic [emr_pkg::MB_W-1:0]   w_op_b;
    logic [emr_pkg::PROD_W-1:0] w_prod;
    logic                       w_y_zero, w_neg, w_r1;

    // shared multiplier
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (i_cmd.mul_sel)
            emr_pkg::MUL_RX2: begin
                w_op_a = emr_pkg::SQ_W'(r_rad_x);
                w_op_b = emr_pkg::MB_W'(r_rad_x);
            end
            emr_pkg::MUL_RY2: begin
                w_op_a = emr_pkg::SQ_W'(r_rad_y);
                w_op_b = emr_pkg::MB_W'(r_rad_y);
            end
            emr_pkg::MUL_INIT: begin
                w_op_a = r_rx2;
                w_op_b = emr_pkg::MB_W'(r_rad_y);
            end
            emr_pkg::MUL_A: begin
                w_op_a = r_ry2;
                w_op_b = r_x;
            end
            emr_pkg::MUL_B: begin
                w_op_a = r_rx2;
                w_op_b = emr_pkg::MB_W'(r_y);
            end
            default: ;
        endcase
    end

    assign w_prod = emr_pkg::PROD_W'(w_op_a) * emr_pkg::PROD_W'(w_op_b);

    assign w_rx2e   = emr_pkg::DEC_W'(r_rx2);
    assign w_ry2e   = emr_pkg::DEC_W'(r_ry2);
    assign w_d_init = w_ry2e - emr_pkg::DEC_W'(w_prod) + emr_pkg::DEC_W'(r_rx2 >> 2);

    assign w_y_zero = (r_y == '0);
    assign w_neg    = r_d[emr_pkg::DEC_W-1];
    assign w_r1     = (r_a < r_b);
    assign w_two_a  = emr_pkg::DEC_W'({r_a, 1'b0});
    assign w_two_b  = emr_pkg::DEC_W'({r_b, 1'b0});

    // region 1 while ry2*x < rx2*y, region 2 keeps its own signs
    always_comb begin
        n_x   = r_x + emr_pkg::OX_W'(1);
        n_y   = r_y - emr_pkg::OY_W'(1);
        w_inc = '0;
        case ({w_r1, w_neg})
            2'b11: begin
                w_inc = w_two_a + w_ry2e;
                n_y   = r_y;
            end
            2'b10: w_inc = w_two_a + w_ry2e - w_two_b;
            2'b01: begin
                w_inc = w_two_b + w_rx2e;
                n_x   = r_x;
            end
            default: w_inc = w_two_b + w_rx2e - w_two_a;
        endcase
        n_d = r_d + w_inc;
    end

    // config and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_rad_x    <= '0;
            r_rad_y    <= '0;
            r_x        <= '0;
            r_y        <= '0;
            r_d        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    emr_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                    emr_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                    emr_pkg::CFG_RADIUS_X: r_rad_x    <= i_cfg_data;
                    emr_pkg::CFG_RADIUS_Y: r_rad_y    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.mul_en && i_cmd.mul_sel == emr_pkg::MUL_INIT) begin
                r_x <= '0;
                r_y <= emr_pkg::OY_W'(r_rad_y);
                r_d <= w_d_init;
            end else if (i_cmd.upd && !w_y_zero) begin
                r_x <= n_x;
                r_y <= n_y;
                r_d <= n_d;
            end
        end
    end

    // products and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                emr_pkg::MUL_RX2: r_rx2 <= emr_pkg::SQ_W'(w_prod);
                emr_pkg::MUL_RY2: r_ry2 <= emr_pkg::SQ_W'(w_prod);
                emr_pkg::MUL_A:   r_a   <= w_prod;
                emr_pkg::MUL_B:   r_b   <= w_prod;
                default: ;
            endcase
        end
        if (i_cmd.upd) begin
            if (w_y_zero) begin
                o_x_right     <= '0;
                o_x_left      <= '0;
                o_y_high      <= '0;
                o_y_low       <= '0;
                o_point_valid <= 1'b0;
                o_last_point  <= 1'b0;
            end else begin
                o_x_right     <= emr_pkg::XO_W'(r_center_x) + emr_pkg::XO_W'(r_x);
                o_x_left      <= emr_pkg::XO_W'(r_center_x) - emr_pkg::XO_W'(r_x);
                o_y_high      <= emr_pkg::YO_W'(r_center_y) + emr_pkg::YO_W'(r_y);
                o_y_low       <= emr_pkg::YO_W'(r_center_y) - emr_pkg::YO_W'(r_y);
                o_point_valid <= 1'b1;
                o_last_point  <= (n_y == '0);
            end
        end
    end

    assign o_y_zero = w_y_zero;

    // a finished walk keeps its state
    `EMR_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, i_cmd.upd && w_y_zero, $stable(r_d) && $stable(r_x) && $stable(r_y))
    // each emitted step moves at least one offset
    `EMR_ASSERT_NEXT(a_step_moves, i_clk, i_rst_n, i_cmd.upd && !w_y_zero, (r_x != $past(r_x)) || (r_y != $past(r_y)))

endmodule

`default_nettype wire

### sv/emr_ctrl.sv
`default_nettype none
`include "ellipse_midpoint_rasterizer_defines.svh"

module emr_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_restart,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output emr_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQX  = 3'd1;
    localparam logic [2:0] ST_SQY  = 3'd2;
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_PA   = 3'd4;
    localparam logic [2:0] ST_PB   = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_restart, n_restart;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state       = r_state;
        n_restart     = r_restart;
        o_in_ready    = 1'b0;
        o_cmd.mul_en  = 1'b0;
        o_cmd.mul_sel = emr_pkg::MUL_RX2;
        o_cmd.upd     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_restart = i_restart;
                    n_state   = ST_SQX;
                end
            end
            ST_SQX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = emr_pkg::MUL_RX2;
                n_state       = ST_SQY;
            end
            ST_SQY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = emr_pkg::MUL_RY2;
                n_state       = r_restart ? ST_INIT : ST_PA;
            end
            ST_INIT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = emr_pkg::MUL_INIT;
                n_state       = ST_PA;
            end
            ST_PA: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = emr_pkg::MUL_A;
                n_state       = ST_PB;
            end
            ST_PB: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = emr_pkg::MUL_B;
                n_state       = ST_UPD;
            end
            ST_UPD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.upd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_restart   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_restart   <= n_restart;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `EMR_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_SQX)
    `EMR_ASSERT_IMPLY(a_rise_from_upd, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_UPD)
    `EMR_ASSERT_NEXT(a_upd_waits, i_clk, i_rst_n, r_state == ST_UPD && r_out_valid && !i_out_ready, r_state == ST_UPD)

endmodule

`default_nettype wire

### dv/ellipse_point_checker.sv
`timescale 1ns / 1ps

module ellipse_point_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [9:0]  i_cfg_data,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [55:0] i_m_tdata,
    input  wire         i_m_tuser,
    input  wire         i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_points,
    output int          o_ellipses
);

    typedef struct packed {
        logic [emr_pkg::XO_W-1:0] x_right;
        logic [emr_pkg::XO_W-1:0] x_left;
        logic [emr_pkg::YO_W-1:0] y_high;
        logic [emr_pkg::YO_W-1:0] y_low;
        logic                     point_valid;
        logic                     last_point;
    } t_point_set;

    t_point_set expected_sets[$];

    logic [emr_pkg::RAD_W-1:0] ctr_x, ctr_y, rad_x, rad_y;
    logic [emr_pkg::OX_W-1:0]  walk_x;
    logic [emr_pkg::OY_W-1:0]  walk_y;
    logic [emr_pkg::DEC_W-1:0] walk_d;

    // one walk step: emit the four points for the current offsets, then move
    task automatic step_walk(input logic restart, output t_point_set ps);
        logic [63:0] rx2, ry2, x, y, d;
        rx2 = 64'(rad_x) * 64'(rad_x);
        ry2 = 64'(rad_y) * 64'(rad_y);
        ps = '0;
        if (restart) begin
            walk_x = '0;
            walk_y = emr_pkg::OY_W'(rad_y);
            d      = ry2 - rx2 * 64'(rad_y) + (rx2 >> 2);
            walk_d = d[emr_pkg::DEC_W-1:0];
        end
        if (walk_y != 0) begin
            x = 64'(walk_x);
            y = 64'(walk_y);
            ps.x_right     = emr_pkg::XO_W'(64'(ctr_x) + x);
            ps.x_left      = emr_pkg::XO_W'(64'(ctr_x) - x);
            ps.y_high      = emr_pkg::YO_W'(64'(ctr_y) + y);
            ps.y_low       = emr_pkg::YO_W'(64'(ctr_y) - y);
            ps.point_valid = 1'b1;
            d = 64'(walk_d);
            if (ry2 * x < rx2 * y) begin
                // region 1: x always moves, y only on a non-negative decision
                if (walk_d[emr_pkg::DEC_W-1]) begin
                    d = d + 64'd2 * ry2 * x + ry2;
                end else begin
                    d = d + 64'd2 * ry2 * x + ry2 - 64'd2 * rx2 * y;
                    y = y - 64'd1;
                end
                x = x + 64'd1;
            end else begin
                // region 2 keeps d from region 1, with its own signs
                if (walk_d[emr_pkg::DEC_W-1]) begin
                    d = d + 64'd2 * rx2 * y + rx2;
                end else begin
                    d = d + 64'd2 * rx2 * y + rx2 - 64'd2 * ry2 * x;
                    x = x + 64'd1;
                end
                y = y - 64'd1;
            end
            walk_d = d[emr_pkg::DEC_W-1:0];
            walk_x = x[emr_pkg::OX_W-1:0];
            walk_y = y[emr_pkg::OY_W-1:0];
            ps.last_point = (walk_y == 0);
        end
    endtask

    always @(posedge i_clk) begin
        t_point_set want;
        t_point_set got;
        if (!i_rst_n) begin
            ctr_x  = '0;
            ctr_y  = '0;
            rad_x  = '0;
            rad_y  = '0;
            walk_x = '0;
            walk_y = '0;
            walk_d = '0;
            expected_sets.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_points     = 0;
            o_ellipses   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    emr_pkg::CFG_CENTER_X: ctr_x = i_cfg_data;
                    emr_pkg::CFG_CENTER_Y: ctr_y = i_cfg_data;
                    emr_pkg::CFG_RADIUS_X: rad_x = i_cfg_data;
                    emr_pkg::CFG_RADIUS_Y: rad_y = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.x_right     = i_m_tdata[12:0];
                got.x_left      = i_m_tdata[25:13];
                got.y_high      = i_m_tdata[37:26];
                got.y_low       = i_m_tdata[49:38];
                got.point_valid = i_m_tuser;
                got.last_point  = i_m_tlast;
                o_checked++;
                if (got.point_valid) o_points++;
                if (got.last_point) o_ellipses++;
                if (expected_sets.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none",
                             $time);
                    $display("%0t:   actual xr=%0d xl=%0d yh=%0d yl=%0d pv=%0b last=%0b",
                             $time, $signed(got.x_right), $signed(got.x_left),
                             $signed(got.y_high), $signed(got.y_low),
                             got.point_valid, got.last_point);
                    o_fail_count++;
                end else begin
                    want = expected_sets.pop_front();
                    if (got !== want) begin
                        $display("%0t: point set mismatch, expected xr=%0d xl=%0d yh=%0d",
                                 $time, $signed(want.x_right), $signed(want.x_left),
                                 $signed(want.y_high));
                        $display("%0t:   expected yl=%0d pv=%0b last=%0b",
                                 $time, $signed(want.y_low),
                                 want.point_valid, want.last_point);
                        $display("%0t:   actual xr=%0d xl=%0d yh=%0d yl=%0d pv=%0b last=%0b",
                                 $time, $signed(got.x_right), $signed(got.x_left),
                                 $signed(got.y_high), $signed(got.y_low),
                                 got.point_valid, got.last_point);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_walk(i_s_tdata[0], want);
                expected_sets.push_back(want);
            end
        end
        o_pending = expected_sets.size();
    end

endmodule

### dv/ellipse_midpoint_rasterizer_tb.sv
`timescale 1ns / 1ps

module ellipse_midpoint_rasterizer_tb;

    // stimulus volume and run bounds
    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 12;      // quiet time after the last expected result
    localparam int LIMIT_CYCLES  = 400_000; // far above the slowest legal run
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off

    // sender idle / receiver stall percentages for each random phase
    localparam int IDLE_TAB[4]  = '{0, 64, 0, 10};
    localparam int STALL_TAB[4] = '{0, 0, 64, 10};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [9:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // checker status
    int fail_count;
    int pending_sets;
    int checked_beats;
    int point_sets;
    int ellipses_done;

    // stimulus bookkeeping
    int idle_pct;
    int stall_pct;
    int items_sent;
    int restarts_sent;
    int settings_used;
    int cycle_count;

    // long hold-off handshake: top bumps hold_seq, receiver process counts it out
    int hold_seq;
    int hold_seen;
    int hold_left;

    ellipse_midpoint_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [0] restart, [7:1] zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [12:0] x_right, [25:13] x_left,
                                         // [37:26] y_high, [49:38] y_low
        .m_axis_tuser  (m_axis_tuser),   // [0] point_valid
        .m_axis_tlast  (m_axis_tlast)    // last_point
    );

    ellipse_point_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_sets),
        .o_checked    (checked_beats),
        .o_points     (point_sets),
        .o_ellipses   (ellipses_done)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // free-running cycle count for the watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles, %0d results still expected",
                 $time, cycle_count, pending_sets);
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever hold_seq moves
    initial begin
        hold_seen = 0;
        hold_left = 0;
    end
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one item and hold it until the block takes the beat;
    // called and returns at a falling edge with tvalid still high
    task automatic send_beat(input logic restart);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (restart) restarts_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and let every expected point set come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_sets != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    // full register setting; only issued while the block is idle
    task automatic apply_setting(input logic [9:0] cx, input logic [9:0] cy,
                                 input logic [9:0] rx, input logic [9:0] ry);
        write_reg(emr_pkg::CFG_RADIUS_X, rx);
        write_reg(emr_pkg::CFG_RADIUS_Y, ry);
        write_reg(emr_pkg::CFG_CENTER_X, cx);
        write_reg(emr_pkg::CFG_CENTER_Y, cy);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // restart followed by advances; a broken walk may restart somewhere inside
    task automatic run_walk(input int n_adv, input bit broken);
        int cut;
        cut = broken ? int'($urandom_range(0, n_adv)) : -1;
        send_beat(1'b1);
        for (int k = 0; k < n_adv; k++) send_beat(k == cut);
    endtask

    // mostly small radii so walks finish, now and then the extremes
    function automatic logic [9:0] pick_radius();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return 10'($urandom_range(0, 12));
        if (roll < 92) return 10'($urandom_range(13, 48));
        if (roll < 96) return ($urandom_range(1) != 0) ? 10'd1023 : 10'd0;
        return 10'($urandom_range(49, 1023));
    endfunction

    function automatic logic [9:0] pick_center();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 10'd0;
        if (roll < 20) return 10'd1023;
        return 10'($urandom_range(0, 1023));
    endfunction

    initial begin
        logic [9:0] rx, ry;
        int walk_len;
        int base_items;
        // every input known from time zero
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = emr_pkg::CFG_CENTER_X;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        items_sent    = 0;
        restarts_sent = 0;
        settings_used = 0;
        hold_seq      = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: finished state straight out of reset, then a restart
        // with zero vertical radius, which also finishes at once
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b1);
        settle();

        // zero horizontal radius keeps the walk in region 2; top-right center,
        // two extra advances after the end
        apply_setting(10'd1023, 10'd1023, 10'd0, 10'd3);
        run_walk(4, 1'b0);
        settle();

        // center at the origin drives x_left and y_low negative
        apply_setting(10'd0, 10'd0, 10'd3, 10'd2);
        run_walk(6, 1'b0);
        settle();

        // largest radii for the widest products, restart in mid walk
        apply_setting(10'd512, 10'd1, 10'd1023, 10'd1023);
        run_walk(3, 1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
        settle();

        // random phases: clean walks with random shapes, some broken walks,
        // some restart/advance noise
        base_items = items_sent;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = IDLE_TAB[phase];
            stall_pct = STALL_TAB[phase];
            while (items_sent < base_items + (phase + 1) * RANDOM_ITEMS / 4) begin
                settle();
                rx = pick_radius();
                ry = pick_radius();
                apply_setting(pick_center(), pick_center(), rx, ry);
                walk_len = int'(rx) + int'(ry) + 2;
                if (walk_len > 100) walk_len = $urandom_range(10, 30);
                if (phase == 0 && hold_seq == 0) begin
                    // block fills up behind a long stall while items keep coming
                    hold_seq <= hold_seq + 1;
                    run_walk((walk_len < 24) ? 24 : walk_len, 1'b0);
                end
                repeat ($urandom_range(1, 2)) begin
                    run_walk(walk_len, $urandom_range(99) < 15);
                end
                if ($urandom_range(99) < 10) begin
                    repeat (5) send_beat($urandom_range(3) == 0);
                end
            end
        end

        settle();
        $display("stimulus: %0d input beats (%0d restarts) over %0d register settings",
                 items_sent, restarts_sent, settings_used);
        $display("results: %0d beats checked, %0d point sets, %0d ellipses run to the end",
                 checked_beats, point_sets, ellipses_done);
        if (fail_count == 0 && pending_sets == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
